[hw/rtl/mstb_pkg.sv]
// Shared types and codes for the multi-slot timer bank.
// Used by the channel interfaces, the slot cells, the head unit and the top level.
package mstb_pkg;

  localparam int SLOT_W  = 3;
  localparam int UNITS_W = 24;
  localparam int TICK_W  = 28;
  localparam int OP_W    = 3;

  localparam int NUM_SLOTS_DEF      = 8;
  localparam int TICKS_PER_UNIT_DEF = 10;

  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
  localparam logic [OP_W-1:0] OP_START   = 3'd2;
  localparam logic [OP_W-1:0] OP_RESET   = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd4;
  localparam logic [OP_W-1:0] OP_STATUS  = 3'd5;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd6;

  localparam logic [1:0] MODE_UNUSED    = 2'd0;
  localparam logic [1:0] MODE_STOPPED   = 2'd1;
  localparam logic [1:0] MODE_RUNNING   = 2'd2;
  localparam logic [1:0] MODE_COMPLETED = 2'd3;

  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [TICK_W-1:0] TICK_MAX = 28'hFFF_FFFF;

  typedef struct packed {
    logic [1:0]        mode;
    logic              oneshot;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] count;
  } slot_t;

  // operation currently walking the ring
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              found;
    logic              units_nz;
    logic              oneshot;
    logic [TICK_W-1:0] period;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic       ok;
    logic       expire;
    logic [1:0] status;
  } head_res_t;

endpackage

[hw/rtl/mstb_if.sv]
// Request and response channel interfaces of the timer bank.
// Depends on mstb_pkg for field widths.
interface mstb_req_if import mstb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SLOT_W-1:0]  slot;
  logic [UNITS_W-1:0] period_units;
  logic               oneshot;

  modport source (output valid, op, slot, period_units, oneshot, input ready);
  modport sink (input valid, op, slot, period_units, oneshot, output ready);
endinterface

interface mstb_rsp_if import mstb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic              ok;
  logic [SLOT_W-1:0] slot_index;
  logic [1:0]        slot_status;
  logic              last;

  modport source (output valid, kind, ok, slot_index, slot_status, last, input ready);
  modport sink (input valid, kind, ok, slot_index, slot_status, last, output ready);
endinterface

[hw/rtl/mstb_cell.sv]
// One timer slot of the rotating ring; takes its neighbor's slot on each shift.
// Depends on mstb_pkg.
module mstb_cell import mstb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t d,
  output slot_t q
);

  // only the mode needs a reset; the other fields are loaded on create
  always_ff @(posedge clk) begin
    if (rst) begin
      q.mode <= MODE_UNUSED;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

[hw/rtl/mstb_head.sv]
// Update unit at the head of the ring: applies the current operation to the
// slot passing by. Depends on mstb_pkg.
module mstb_head import mstb_pkg::*; (
  input  slot_t     cur,
  input  cmd_t      cmd,
  input  logic      at_slot,
  output slot_t     nxt,
  output head_res_t res
);

  logic              live;
  logic [TICK_W-1:0] cnt_inc;

  assign live    = (cur.mode == MODE_RUNNING) || (cur.mode == MODE_COMPLETED);
  assign cnt_inc = cur.count + 1'b1;

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cmd.op)
      OP_CREATE: begin
        if (!cmd.found && cmd.units_nz && cur.mode == MODE_UNUSED) begin
          nxt.mode    = MODE_STOPPED;
          nxt.oneshot = cmd.oneshot;
          nxt.period  = cmd.period;
          nxt.count   = '0;
          res.hit     = 1'b1;
          res.ok      = 1'b1;
          res.status  = MODE_STOPPED;
        end
      end
      OP_DESTROY: begin
        if (at_slot) begin
          nxt.mode   = MODE_UNUSED;
          res.hit    = 1'b1;
          res.ok     = 1'b1;
          res.status = MODE_UNUSED;
        end
      end
      OP_START: begin
        if (at_slot) begin
          res.hit    = 1'b1;
          res.status = cur.mode;
          if (cur.mode != MODE_UNUSED) begin
            nxt.mode   = MODE_RUNNING;
            res.ok     = 1'b1;
            res.status = MODE_RUNNING;
          end
        end
      end
      OP_RESET: begin
        if (at_slot) begin
          res.hit    = 1'b1;
          res.status = cur.mode;
          if (cmd.units_nz && live) begin
            nxt.period = cmd.period;
            nxt.count  = '0;
            res.ok     = 1'b1;
          end
        end
      end
      OP_STOP: begin
        if (at_slot) begin
          res.hit    = 1'b1;
          res.status = cur.mode;
          if (live) begin
            nxt.mode   = MODE_STOPPED;
            res.ok     = 1'b1;
            res.status = MODE_STOPPED;
          end
        end
      end
      OP_STATUS: begin
        if (at_slot) begin
          res.hit    = 1'b1;
          res.ok     = 1'b1;
          res.status = cur.mode;
        end
      end
      OP_TICK: begin
        if (cur.mode == MODE_RUNNING) begin
          if (cnt_inc >= cur.period) begin
            nxt.count  = '0;
            nxt.mode   = cur.oneshot ? MODE_COMPLETED : MODE_RUNNING;
            res.expire = 1'b1;
            res.status = nxt.mode;
          end else begin
            nxt.count = cnt_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/multi_slot_timer_bank.sv]
// Multi-slot timer bank: create, destroy, start, reset, stop, status and tick
// operations over NUM_SLOTS timer slots.
// Channels: req (sink) carries op, slot, period_units, oneshot; rsp (source)
// carries kind, ok, slot_index, slot_status, last. A transfer happens when
// valid and ready are both high at a rising clock edge.
// The slots sit in a ring of cells that rotates one place per cycle, unless
// held for the output, past a single update unit, so every operation walks the
// whole ring once, in slot order, starting from slot 0. After the walk the
// done state loads the final result into the output register.
// req.ready is high only in the idle state, between items, so a new request
// is not taken until the previous item's final result has been loaded. The
// period multiply is done at the request transfer.
// A tick gives one expiry result per expiring slot and then a finish result;
// other operations give one answer. Results leave through one output
// register; while it is full and not taken, the ring holds its place when an
// expiry is to be loaded, and the done state waits.
// Reset (rst, synchronous) marks every slot unused and drops any pending
// result; the block is ready right after.
module multi_slot_timer_bank import mstb_pkg::*; #(
  parameter int NUM_SLOTS      = NUM_SLOTS_DEF,
  parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
  input logic       clk,
  input logic       rst,
  mstb_req_if.sink  req,
  mstb_rsp_if.source rsp
);

  localparam int STEP_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PW_RAW  = UNITS_W + $clog2(TICKS_PER_UNIT + 1);
  localparam int PROD_W  = (PW_RAW > TICK_W + 1) ? PW_RAW : TICK_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;

  logic [OP_W-1:0]   op_r;
  logic              oneshot_r;
  logic              units_nz_r;
  logic [PROD_W-1:0] prod;

  logic              ans_ok;
  logic [SLOT_W-1:0] ans_idx;
  logic [1:0]        ans_status;

  logic              out_valid;
  logic [1:0]        out_kind;
  logic              out_ok;
  logic [SLOT_W-1:0] out_idx;
  logic [1:0]        out_status;
  logic              out_last;

  slot_t             ring [NUM_SLOTS];
  slot_t             head_nxt;
  head_res_t         head_res;
  cmd_t              cmd;
  logic              at_slot;
  logic              out_can;
  logic              out_load;
  logic              advance;
  logic              shift;
  logic              last_step;
  logic              slot_op;
  logic              walk_slot_op;

  assign out_can   = !out_valid || rsp.ready;
  assign advance   = !head_res.expire || out_can;
  assign shift     = (state == ST_STEP) && advance;
  assign last_step = (step == STEP_W'(NUM_SLOTS - 1));
  assign out_load  = ((state == ST_STEP) && advance && head_res.expire) ||
                     ((state == ST_DONE) && out_can);

  // slot ops carry their target in ans_idx until the walk finds it
  assign walk_slot_op = (op_r == OP_DESTROY) || (op_r == OP_START) || (op_r == OP_RESET) ||
                        (op_r == OP_STOP) || (op_r == OP_STATUS);
  assign at_slot      = walk_slot_op && (32'(step) == 32'(ans_idx));

  assign slot_op = (req.op == OP_DESTROY) || (req.op == OP_START) ||
                   (req.op == OP_RESET) || (req.op == OP_STOP) || (req.op == OP_STATUS);

  always_comb begin
    cmd.op       = op_r;
    cmd.found    = ans_ok;
    cmd.units_nz = units_nz_r;
    cmd.oneshot  = oneshot_r;
    cmd.period   = (prod > PROD_W'(TICK_MAX)) ? TICK_MAX : prod[TICK_W-1:0];
  end

  mstb_head u_head (
    .cur     (ring[NUM_SLOTS-1]),
    .cmd     (cmd),
    .at_slot (at_slot),
    .nxt     (head_nxt),
    .res     (head_res)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      mstb_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (head_nxt),
        .q     (ring[i])
      );
    end else begin : g_rest
      mstb_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (ring[i-1]),
        .q     (ring[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_r       <= req.op;
            oneshot_r  <= req.oneshot;
            units_nz_r <= (req.period_units != '0);
            prod       <= PROD_W'(req.period_units) * PROD_W'(TICKS_PER_UNIT);
            ans_ok     <= 1'b0;
            ans_status <= MODE_UNUSED;
            ans_idx    <= slot_op ? req.slot : '0;
            step       <= '0;
            state      <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (advance) begin
            if (head_res.hit) begin
              ans_ok     <= head_res.ok;
              ans_status <= head_res.status;
              ans_idx    <= SLOT_W'(step);
            end
            if (head_res.expire) begin
              out_valid  <= 1'b1;
              out_kind   <= KIND_EXPIRY;
              out_ok     <= 1'b1;
              out_idx    <= SLOT_W'(step);
              out_status <= head_res.status;
              out_last   <= 1'b0;
            end
            if (last_step) begin
              step  <= '0;
              state <= ST_DONE;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_can) begin
            out_valid <= 1'b1;
            out_last  <= 1'b1;
            if (op_r == OP_TICK) begin
              out_kind   <= KIND_DONE;
              out_ok     <= 1'b1;
              out_idx    <= '0;
              out_status <= MODE_UNUSED;
            end else begin
              out_kind   <= KIND_ANSWER;
              out_ok     <= ans_ok;
              out_idx    <= ans_idx;
              out_status <= ans_status;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.ok          = out_ok;
  assign rsp.slot_index  = out_idx;
  assign rsp.slot_status = out_status;
  assign rsp.last        = out_last;

  // ring must be back in its rest alignment whenever it is not walking
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_STEP) |-> (step == '0))
    else $error("ring walk left misaligned");

  // expiries only come from a tick walk
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && head_res.expire) |-> (op_r == OP_TICK))
    else $error("expiry outside tick");

  // only the closing result of an item is marked last
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind != KIND_EXPIRY)))
    else $error("last flag does not match result kind");

  // an accepted request starts a walk on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_STEP))
    else $error("request transfer did not start a walk");

endmodule
